@@ hdl/assert_macros.svh @@
// Assertion macros for the RTL of the blur unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define BB_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define BB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/bb3_pkg.sv @@
// Types, register indexes and divide constants of the 3x3 box blur unit.
`default_nettype none
package bb3_pkg;

    typedef logic [23:0] pix_t;

    localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd1;

    localparam int RECIP_SHIFT = 15;

    // Reciprocal of a neighbour count, scaled by 2^RECIP_SHIFT and rounded up.
    // Exact for every dividend up to 9*255 plus rounding.
    function automatic logic [15:0] recip(input logic [3:0] cnt);
        logic [15:0] m;
        case (cnt)
            4'd1:    m = 16'd32768;
            4'd2:    m = 16'd16384;
            4'd3:    m = 16'd10923;
            4'd4:    m = 16'd8192;
            4'd6:    m = 16'd5462;
            4'd9:    m = 16'd3641;
            default: m = 16'd32768;
        endcase
        return m;
    endfunction

endpackage
`default_nettype wire

@@ hdl/box_blur_3x3_rgb_unit.sv @@
// 3x3 box blur over a raster RGB stream with two line stores in one memory.
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data  | in
//  pixel   | s_valid s_ready s_red s_green s_blue    | in
//  result  | m_valid m_ready m_out_* m_run_last ...  | out
//
// One pixel gives 0 to 4 results: a line memory read, then for each result
// the masked window sum and the reciprocal multiply.
// The last result of a pixel waits in the output register while the next
// pixel is taken. Reset clears the position and the frame size (640x480);
// the line memory needs no clearing. A stalled result holds the sequencer.
// A config beat is taken only while the sequencer is idle, and a pending
// config write holds off the pixel input.
`default_nettype none
`include "assert_macros.svh"
module box_blur_3x3_rgb_unit
    import bb3_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [10:0] cfg_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_red,
    input  wire logic [7:0]  s_green,
    input  wire logic [7:0]  s_blue,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [9:0]       m_out_row,
    output logic [9:0]       m_out_col,
    output logic [7:0]       m_out_red,
    output logic [7:0]       m_out_green,
    output logic [7:0]       m_out_blue,
    output logic             m_run_last,
    output logic             m_frame_done
);

    localparam int CW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int DIMW = 18;
    localparam int CXW  = (CW > 10) ? CW : 10;
    localparam int RXW  = (RW > 10) ? RW : 10;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_SUM  = 2'd2;
    localparam logic [1:0] S_DIV  = 2'd3;

    logic [1:0]    state_reg;
    logic [10:0]   fw_reg, fh_reg;
    logic [RW-1:0] row_reg;
    logic [CW-1:0] col_reg;

    // line memory: older row in the upper half, newer row in the lower half
    logic [47:0]   line_mem [MAX_WIDTH];
    logic [47:0]   rd_reg;

    pix_t          win_reg [9];
    pix_t          pix_reg;
    logic [RW-1:0] item_row_reg;
    logic [CW-1:0] item_col_reg;
    logic          r_ge1_reg, r_ge2_reg, r_last_reg;
    logic          c_ge1_reg, c_ge2_reg, c_last_reg;
    logic [3:0]    slot_reg;
    logic [1:0]    sel_reg;
    logic [11:0]   sum_r_reg, sum_g_reg, sum_b_reg;
    logic [3:0]    cnt_reg;

    logic          m_valid_reg;
    logic [9:0]    row_o_reg, col_o_reg;
    logic [7:0]    red_o_reg, green_o_reg, blue_o_reg;
    logic          last_o_reg, done_o_reg;

    logic [DIMW-1:0] w_eff, h_eff;
    logic [RW-1:0]   cur_r;
    logic [CW-1:0]   cur_c;
    logic            s_beat, out_load;

    // clamp the frame size into 1..MAX
    always_comb begin
        if (fw_reg == 11'd0) w_eff = DIMW'(1);
        else if (DIMW'(fw_reg) > DIMW'(MAX_WIDTH)) w_eff = DIMW'(MAX_WIDTH);
        else w_eff = DIMW'(fw_reg);
        if (fh_reg == 11'd0) h_eff = DIMW'(1);
        else if (DIMW'(fh_reg) > DIMW'(MAX_HEIGHT)) h_eff = DIMW'(MAX_HEIGHT);
        else h_eff = DIMW'(fh_reg);
    end

    // restart the frame if the position has left the frame
    always_comb begin
        if (DIMW'(row_reg) >= h_eff || DIMW'(col_reg) >= w_eff) begin
            cur_r = '0;
            cur_c = '0;
        end else begin
            cur_r = row_reg;
            cur_c = col_reg;
        end
    end

    // hold pixels while a config beat waits, so the two never share an edge
    assign s_ready   = (state_reg == S_IDLE) && !cfg_valid;
    assign cfg_ready = (state_reg == S_IDLE);
    assign s_beat    = s_valid && s_ready;
    assign out_load  = (state_reg == S_DIV) && (!m_valid_reg || m_ready);

    // pick the earliest pending result slot: bit 1 = current row, bit 0 = current col
    logic [1:0] sel;
    always_comb begin
        if (slot_reg[0]) sel = 2'd0;
        else if (slot_reg[1]) sel = 2'd1;
        else if (slot_reg[2]) sel = 2'd2;
        else sel = 2'd3;
    end

    // neighbour masks and masked sums for the selected slot
    logic [2:0]  rm, cm;
    logic [1:0]  nrow, ncol;
    logic [11:0] sr, sg, sb;
    always_comb begin
        if (sel[1]) rm = {1'b1, r_ge1_reg, 1'b0};
        else rm = {1'b1, 1'b1, r_ge2_reg};
        if (sel[0]) cm = {1'b1, c_ge1_reg, 1'b0};
        else cm = {1'b1, 1'b1, c_ge2_reg};
        nrow = 2'(rm[0]) + 2'(rm[1]) + 2'(rm[2]);
        ncol = 2'(cm[0]) + 2'(cm[1]) + 2'(cm[2]);
        sr = '0;
        sg = '0;
        sb = '0;
        for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 3; j++) begin
                if (rm[k] && cm[j]) begin
                    sr = sr + 12'(win_reg[k*3+j][23:16]);
                    sg = sg + 12'(win_reg[k*3+j][15:8]);
                    sb = sb + 12'(win_reg[k*3+j][7:0]);
                end
            end
        end
    end

    // divide by the count through its scaled reciprocal
    logic [15:0] mul;
    logic [11:0] half;
    logic [27:0] pr, pg, pb;
    always_comb begin
        mul  = recip(cnt_reg);
        half = 12'(cnt_reg >> 1);
        pr   = 28'(sum_r_reg + half) * 28'(mul);
        pg   = 28'(sum_g_reg + half) * 28'(mul);
        pb   = 28'(sum_b_reg + half) * 28'(mul);
    end

    logic [RXW-1:0] orow;
    logic [CXW-1:0] ocol;
    logic [3:0]     slot_left;
    always_comb begin
        orow      = RXW'(item_row_reg) - RXW'(!sel_reg[1]);
        ocol      = CXW'(item_col_reg) - CXW'(!sel_reg[0]);
        slot_left = slot_reg & ~(4'd1 << sel_reg);
    end

    // control: sequencer, position, frame size, output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            fw_reg      <= 11'd640;
            fh_reg      <= 11'd480;
            row_reg     <= '0;
            col_reg     <= '0;
            slot_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (out_load) m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE: begin
                    if (s_beat) state_reg <= S_READ;
                end
                S_READ: begin
                    slot_reg <= {r_last_reg & c_last_reg, r_last_reg & c_ge1_reg,
                                 r_ge1_reg & c_last_reg, r_ge1_reg & c_ge1_reg};
                    if ((r_ge1_reg || r_last_reg) && (c_ge1_reg || c_last_reg))
                        state_reg <= S_SUM;
                    else
                        state_reg <= S_IDLE;
                end
                S_SUM: begin
                    state_reg <= S_DIV;
                end
                S_DIV: begin
                    if (out_load) begin
                        slot_reg  <= slot_left;
                        state_reg <= (slot_left != 4'd0) ? S_SUM : S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase

            // advance the raster position on every pixel beat
            if (s_beat) begin
                if (DIMW'(cur_c) + DIMW'(1) >= w_eff) begin
                    col_reg <= '0;
                    row_reg <= (DIMW'(cur_r) + DIMW'(1) >= h_eff) ? '0 : cur_r + RW'(1);
                end else begin
                    col_reg <= cur_c + CW'(1);
                end
            end

            // a write to a listed register restarts the frame
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_FRAME_WIDTH: begin
                        fw_reg  <= cfg_data;
                        row_reg <= '0;
                        col_reg <= '0;
                    end
                    CFG_FRAME_HEIGHT: begin
                        fh_reg  <= cfg_data;
                        row_reg <= '0;
                        col_reg <= '0;
                    end
                    default: ;
                endcase
            end
        end
    end

    // line memory: read on the pixel beat, write back in the next cycle (S_READ)
    always_ff @(posedge aclk) begin
        if (s_beat) rd_reg <= line_mem[cur_c];
        if (state_reg == S_READ) line_mem[item_col_reg] <= {rd_reg[23:0], pix_reg};
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (s_beat) begin
            pix_reg      <= {s_red, s_green, s_blue};
            item_row_reg <= cur_r;
            item_col_reg <= cur_c;
            r_ge1_reg    <= (cur_r != '0);
            r_ge2_reg    <= (DIMW'(cur_r) >= DIMW'(2));
            r_last_reg   <= (DIMW'(cur_r) == h_eff - DIMW'(1));
            c_ge1_reg    <= (cur_c != '0);
            c_ge2_reg    <= (DIMW'(cur_c) >= DIMW'(2));
            c_last_reg   <= (DIMW'(cur_c) == w_eff - DIMW'(1));
        end
        if (state_reg == S_READ) begin
            for (int k = 0; k < 3; k++) begin
                win_reg[k*3]   <= win_reg[k*3+1];
                win_reg[k*3+1] <= win_reg[k*3+2];
            end
            win_reg[2] <= rd_reg[47:24];
            win_reg[5] <= rd_reg[23:0];
            win_reg[8] <= pix_reg;
        end
        if (state_reg == S_SUM) begin
            sel_reg   <= sel;
            sum_r_reg <= sr;
            sum_g_reg <= sg;
            sum_b_reg <= sb;
            cnt_reg   <= 4'(nrow) * 4'(ncol);
        end
        if (out_load) begin
            row_o_reg   <= orow[9:0];
            col_o_reg   <= ocol[9:0];
            red_o_reg   <= pr[RECIP_SHIFT+7:RECIP_SHIFT];
            green_o_reg <= pg[RECIP_SHIFT+7:RECIP_SHIFT];
            blue_o_reg  <= pb[RECIP_SHIFT+7:RECIP_SHIFT];
            last_o_reg  <= (slot_left == 4'd0);
            done_o_reg  <= (sel_reg == 2'd3);
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_out_row    = row_o_reg;
    assign m_out_col    = col_o_reg;
    assign m_out_red    = red_o_reg;
    assign m_out_green  = green_o_reg;
    assign m_out_blue   = blue_o_reg;
    assign m_run_last   = last_o_reg;
    assign m_frame_done = done_o_reg;

    `BB_ASSERT_NEXT(a_beat_reads, s_beat, state_reg == S_READ, "pixel beat did not start a read")
    `BB_ASSERT_NOW(a_div_has_slot, state_reg == S_DIV, slot_reg != 4'd0, "divide with no slot")
    `BB_ASSERT_NOW(a_done_is_last, m_valid && m_frame_done, m_run_last, "frame end not last")
    `BB_ASSERT_NOW(a_cnt_legal, state_reg == S_DIV,
        cnt_reg == 4'd1 || cnt_reg == 4'd2 || cnt_reg == 4'd3 ||
        cnt_reg == 4'd4 || cnt_reg == 4'd6 || cnt_reg == 4'd9, "bad neighbour count")

endmodule
`default_nettype wire
